/* rtl/mhtq_pkg.sv */
// Shared types, constants and command codes for the min-heap timer queue.
`timescale 1ns / 1ps
package mhtq_pkg;

   localparam int CAPACITY  = 64;
   localparam int ID_COUNT  = 1024;
   localparam int TIME_BITS = 32;

   localparam int ID_W    = 10;
   localparam int TMO_W   = 16;
   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int ID_AW   = $clog2(ID_COUNT);
   localparam int HEAP_W  = TIME_BITS + ID_W;

   typedef enum logic [1:0] {
      KIND_ADD   = 2'd0,
      KIND_FIRE  = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CAUSE_EXPIRED  = 2'd0,
      CAUSE_FIRED    = 2'd1,
      CAUSE_REJECTED = 2'd2,
      CAUSE_SPARE    = 2'd3
   } cause_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] expiry;
      logic [ID_W-1:0]      owner;
   } heap_entry_type;

   // Datapath micro-operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT,
      OP_LOAD,
      OP_CLEAR,
      OP_TOP_RD,
      OP_TAKE_TOP,
      OP_EMIT_FINAL,
      OP_SLOT_RD,
      OP_HEAP_RD_SLOT,
      OP_EMIT_FIRE,
      OP_EMIT_FULL,
      OP_ARM_OLD,
      OP_ARM_NEW,
      OP_REMOVE,
      OP_REMOVE_LOAD,
      OP_DN_RD,
      OP_DN_B,
      OP_DN_SEL,
      OP_DN_SWAP,
      OP_UP_RD,
      OP_UP_SWAP,
      OP_WR_MOVER
   } op_type;

   typedef struct packed {
      kind_type kind;
      logic     init_last;
      logic     id_ok;
      logic     cnt_zero;
      logic     due;
      logic     pend;
      logic     out_free;
      logic     armed;
      logic     full;
      logic     rm_more;
      logic     c_lt_n;
      logic     c1_lt_n;
      logic     moved;
      logic     m_earlier_b;
      logic     i_zero;
      logic     p_earlier_m;
   } status_type;

   // a strictly earlier than b, wrap-safe
   function automatic logic earlier(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] d;
      d = a - b;
      return d[TIME_BITS-1];
   endfunction

endpackage

/* rtl/mhtq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mhtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read; read data holds when not reading
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/mhtq_ctrl.sv */
// Controller state machine that sequences heap commands.
`timescale 1ns / 1ps
module mhtq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mhtq_pkg::status_type st,
   output mhtq_pkg::op_type    op
);
   import mhtq_pkg::*;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_T_RD,
      S_T_CHK,
      S_T_FIN,
      S_LOOKUP,
      S_CHECK,
      S_F_EMIT,
      S_A_EMIT,
      S_RM,
      S_RM_LD,
      S_DN_RD,
      S_DN_B,
      S_DN_SEL,
      S_DN_CMP,
      S_UP_RD,
      S_UP_CMP,
      S_WR_M
   } state_type;

   state_type state_ff, state_in;
   logic      is_tick;

   assign req_stall = (state_ff != S_IDLE);
   assign is_tick   = (st.kind == KIND_TICK);

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      case (state_ff)
         S_INIT: begin
            op = OP_INIT;
            if (st.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (st.kind)
               KIND_CLEAR: begin
                  op       = OP_CLEAR;
                  state_in = S_IDLE;
               end
               KIND_TICK: state_in = S_T_RD;
               default: begin
                  if (st.id_ok) begin
                     op       = OP_SLOT_RD;
                     state_in = S_LOOKUP;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_T_RD: begin
            if (st.cnt_zero) begin
               state_in = S_T_FIN;
            end else begin
               op       = OP_TOP_RD;
               state_in = S_T_CHK;
            end
         end
         S_T_CHK: begin
            if (!st.due) begin
               state_in = S_T_FIN;
            end else if (!st.pend || st.out_free) begin
               op       = OP_TAKE_TOP;
               state_in = S_RM;
            end
         end
         S_T_FIN: begin
            if (!st.pend) begin
               state_in = S_IDLE;
            end else if (st.out_free) begin
               op       = OP_EMIT_FINAL;
               state_in = S_IDLE;
            end
         end
         S_LOOKUP: begin
            op       = OP_HEAP_RD_SLOT;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (st.kind == KIND_FIRE) begin
               state_in = st.armed ? S_F_EMIT : S_IDLE;
            end else if (st.armed) begin
               op       = OP_ARM_OLD;
               state_in = S_DN_RD;
            end else if (st.full) begin
               state_in = S_A_EMIT;
            end else begin
               op       = OP_ARM_NEW;
               state_in = S_DN_RD;
            end
         end
         S_F_EMIT: begin
            if (st.out_free) begin
               op       = OP_EMIT_FIRE;
               state_in = S_RM;
            end
         end
         S_A_EMIT: begin
            if (st.out_free) begin
               op       = OP_EMIT_FULL;
               state_in = S_IDLE;
            end
         end
         S_RM: begin
            op = OP_REMOVE;
            if (st.rm_more) begin
               state_in = S_RM_LD;
            end else begin
               state_in = is_tick ? S_T_RD : S_IDLE;
            end
         end
         S_RM_LD: begin
            op       = OP_REMOVE_LOAD;
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            if (!st.c_lt_n) begin
               state_in = st.moved ? S_WR_M : S_UP_RD;
            end else begin
               op       = OP_DN_RD;
               state_in = S_DN_B;
            end
         end
         S_DN_B: begin
            op       = OP_DN_B;
            state_in = st.c1_lt_n ? S_DN_SEL : S_DN_CMP;
         end
         S_DN_SEL: begin
            op       = OP_DN_SEL;
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            if (st.m_earlier_b) begin
               state_in = st.moved ? S_WR_M : S_UP_RD;
            end else begin
               op       = OP_DN_SWAP;
               state_in = S_DN_RD;
            end
         end
         S_UP_RD: begin
            if (st.i_zero) begin
               state_in = S_WR_M;
            end else begin
               op       = OP_UP_RD;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (st.p_earlier_m) begin
               state_in = S_WR_M;
            end else begin
               op       = OP_UP_SWAP;
               state_in = S_UP_RD;
            end
         end
         S_WR_M: begin
            op       = OP_WR_MOVER;
            state_in = is_tick ? S_T_RD : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* rtl/mhtq_datapath.sv */
// Datapath: heap and slot memories, sift registers and the result register.
`timescale 1ns / 1ps
module mhtq_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  mhtq_pkg::op_type                  op,
   output mhtq_pkg::status_type              st,
   input  logic [1:0]                        req_kind,
   input  logic [mhtq_pkg::ID_W-1:0]         req_timer_id,
   input  logic [mhtq_pkg::TMO_W-1:0]        req_timeout,
   input  logic [mhtq_pkg::TIME_BITS-1:0]    req_now,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mhtq_pkg::ID_W-1:0]         rsp_event_id,
   output logic [1:0]                        rsp_cause,
   output logic                              rsp_last
);
   import mhtq_pkg::*;

   kind_type             kind_ff;
   logic [ID_W-1:0]      id_ff;
   logic [TIME_BITS-1:0] exp_ff, now_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ID_AW-1:0]     init_ff, init_in;
   logic [IDX_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     c_ff, c_in;
   heap_entry_type       m_ff, m_in, b_ff, b_in;
   logic                 moved_ff, moved_in;
   logic                 pend_ff, pend_in;
   logic [ID_W-1:0]      pend_id_ff, pend_id_in;
   logic                 out_valid_ff, out_valid_in;
   logic [ID_W-1:0]      out_id_ff, out_id_in;
   cause_type            out_cause_ff, out_cause_in;
   logic                 out_last_ff, out_last_in;

   logic                 heap_we, heap_re;
   logic [IDX_W-1:0]     heap_waddr, heap_raddr;
   heap_entry_type       heap_wdata, heap_rdata;
   logic [HEAP_W-1:0]    heap_rdata_raw;
   logic                 slot_we, slot_re;
   logic [ID_AW-1:0]     slot_waddr, slot_raddr;
   logic [IDX_W-1:0]     slot_wdata, slot_rdata;

   logic                 out_free, load_out;
   logic [CNT_W-1:0]     c_first, cnt_dec;
   logic [IDX_W-1:0]     parent;
   logic [TIME_BITS-1:0] top_diff;

   mhtq_ram #(.WIDTH(HEAP_W), .DEPTH(CAPACITY)) u_heap_ram (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_en   (heap_re),
      .rd_addr (heap_raddr),
      .rd_data (heap_rdata_raw)
   );

   mhtq_ram #(.WIDTH(IDX_W), .DEPTH(ID_COUNT)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (slot_re),
      .rd_addr (slot_raddr),
      .rd_data (slot_rdata)
   );

   assign heap_rdata = heap_rdata_raw;
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign c_first    = {i_ff, 1'b1};
   assign cnt_dec    = cnt_ff - CNT_W'(1);
   assign parent     = (i_ff - IDX_W'(1)) >> 1;
   assign top_diff   = heap_rdata.expiry - now_ff;

   // status toward the controller
   always_comb begin
      st.kind        = kind_ff;
      st.init_last   = (init_ff == ID_AW'(ID_COUNT - 1));
      st.id_ok       = (32'(id_ff) < ID_COUNT);
      st.cnt_zero    = (cnt_ff == '0);
      st.due         = (top_diff == '0) || top_diff[TIME_BITS-1];
      st.pend        = pend_ff;
      st.out_free    = out_free;
      st.armed       = (CNT_W'(i_ff) < cnt_ff) && (heap_rdata.owner == id_ff);
      st.full        = (cnt_ff >= CNT_W'(CAPACITY));
      st.rm_more     = (CNT_W'(i_ff) < cnt_dec);
      st.c_lt_n      = (c_first < cnt_ff);
      st.c1_lt_n     = ((c_ff + CNT_W'(1)) < cnt_ff);
      st.moved       = moved_ff;
      st.m_earlier_b = earlier(m_ff.expiry, b_ff.expiry);
      st.i_zero      = (i_ff == '0);
      st.p_earlier_m = earlier(heap_rdata.expiry, m_ff.expiry);
   end

   // memory ports
   always_comb begin
      heap_re    = 1'b0;
      heap_raddr = '0;
      heap_we    = 1'b0;
      heap_waddr = i_ff;
      heap_wdata = m_ff;
      slot_re    = 1'b0;
      slot_raddr = id_ff[ID_AW-1:0];
      slot_we    = 1'b0;
      slot_waddr = m_ff.owner[ID_AW-1:0];
      slot_wdata = i_ff;
      case (op)
         OP_INIT: begin
            slot_we    = 1'b1;
            slot_waddr = init_ff;
            slot_wdata = '0;
         end
         OP_TOP_RD: heap_re = 1'b1;
         OP_SLOT_RD: slot_re = 1'b1;
         OP_HEAP_RD_SLOT: begin
            heap_re    = 1'b1;
            heap_raddr = slot_rdata;
         end
         OP_REMOVE: begin
            heap_re    = 1'b1;
            heap_raddr = cnt_dec[IDX_W-1:0];
         end
         OP_DN_RD: begin
            heap_re    = 1'b1;
            heap_raddr = c_first[IDX_W-1:0];
         end
         OP_DN_B: begin
            heap_re    = 1'b1;
            heap_raddr = c_ff[IDX_W-1:0] + IDX_W'(1);
         end
         OP_UP_RD: begin
            heap_re    = 1'b1;
            heap_raddr = parent;
         end
         OP_DN_SWAP: begin
            heap_we    = 1'b1;
            heap_wdata = b_ff;
            slot_we    = 1'b1;
            slot_waddr = b_ff.owner[ID_AW-1:0];
         end
         OP_UP_SWAP: begin
            heap_we    = 1'b1;
            heap_wdata = heap_rdata;
            slot_we    = 1'b1;
            slot_waddr = heap_rdata.owner[ID_AW-1:0];
         end
         OP_WR_MOVER: begin
            heap_we = 1'b1;
            slot_we = 1'b1;
         end
         default: ;
      endcase
   end

   // register updates per command
   always_comb begin
      cnt_in       = cnt_ff;
      init_in      = init_ff;
      i_in         = i_ff;
      c_in         = c_ff;
      m_in         = m_ff;
      b_in         = b_ff;
      moved_in     = moved_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      load_out     = 1'b0;
      out_id_in    = out_id_ff;
      out_cause_in = out_cause_ff;
      out_last_in  = out_last_ff;
      case (op)
         OP_INIT: init_in = init_ff + ID_AW'(1);
         OP_CLEAR: cnt_in = '0;
         OP_TAKE_TOP: begin
            load_out     = pend_ff;
            out_id_in    = pend_id_ff;
            out_cause_in = CAUSE_EXPIRED;
            out_last_in  = 1'b0;
            pend_in      = 1'b1;
            pend_id_in   = heap_rdata.owner;
            i_in         = '0;
         end
         OP_EMIT_FINAL: begin
            load_out     = 1'b1;
            out_id_in    = pend_id_ff;
            out_cause_in = CAUSE_EXPIRED;
            out_last_in  = 1'b1;
            pend_in      = 1'b0;
         end
         OP_HEAP_RD_SLOT: i_in = slot_rdata;
         OP_EMIT_FIRE: begin
            load_out     = 1'b1;
            out_id_in    = id_ff;
            out_cause_in = CAUSE_FIRED;
            out_last_in  = 1'b1;
         end
         OP_EMIT_FULL: begin
            load_out     = 1'b1;
            out_id_in    = id_ff;
            out_cause_in = CAUSE_REJECTED;
            out_last_in  = 1'b1;
         end
         OP_ARM_OLD: begin
            m_in     = '{expiry: exp_ff, owner: id_ff};
            moved_in = 1'b0;
         end
         OP_ARM_NEW: begin
            m_in     = '{expiry: exp_ff, owner: id_ff};
            moved_in = 1'b0;
            i_in     = cnt_ff[IDX_W-1:0];
            cnt_in   = cnt_ff + CNT_W'(1);
         end
         OP_REMOVE: cnt_in = cnt_dec;
         OP_REMOVE_LOAD: begin
            m_in     = heap_rdata;
            moved_in = 1'b0;
         end
         OP_DN_RD: c_in = c_first;
         OP_DN_B: b_in = heap_rdata;
         OP_DN_SEL: begin
            if (earlier(heap_rdata.expiry, b_ff.expiry)) begin
               b_in = heap_rdata;
               c_in = c_ff + CNT_W'(1);
            end
         end
         OP_DN_SWAP: begin
            i_in     = c_ff[IDX_W-1:0];
            moved_in = 1'b1;
         end
         OP_UP_SWAP: i_in = parent;
         default: ;
      endcase
      out_valid_in = load_out ? 1'b1 : (out_valid_ff && rsp_stall);
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         init_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         init_ff      <= init_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold payload
   always_ff @(posedge clock) begin
      if (op == OP_LOAD) begin
         kind_ff <= kind_type'(req_kind);
         id_ff   <= req_timer_id;
         now_ff  <= req_now;
         exp_ff  <= req_now + TIME_BITS'(req_timeout);
      end
      i_ff       <= i_in;
      c_ff       <= c_in;
      m_ff       <= m_in;
      b_ff       <= b_in;
      moved_ff   <= moved_in;
      pend_id_ff <= pend_id_in;
      if (load_out) begin
         out_id_ff    <= out_id_in;
         out_cause_ff <= out_cause_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_event_id = out_id_ff;
   assign rsp_cause    = out_cause_ff;
   assign rsp_last     = out_last_ff;

endmodule

/* rtl/min_heap_timer_queue.sv */
// Top level of the min-heap timer queue.
//
// Input channel req_*: one command per item (add or re-arm, fire, tick,
// clear) with timer id, timeout and current time. Result channel rsp_*:
// event id, cause and a last flag on the final result of each command.
// Both channels use valid/stall; an item moves when valid is high and
// stall is low.
// One command is worked at a time; the heap memory has one read port.
// The input is stalled from the accepting edge until the command is
// done. An add or fire looks up the slot and heap entry, then sifts
// the heap, which holds up to 64 entries; a tick removes each expired
// timer in turn, with a sift after each.
// A finished result waits in an output register while the command goes
// on; when the receiver stalls, the block waits only where it must put a
// new result there.
// Reset empties the queue and the result register, then clears all 1024
// slot memory entries with req_stall held high.
`timescale 1ns / 1ps
module min_heap_timer_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_kind,
   input  logic [mhtq_pkg::ID_W-1:0]      req_timer_id,
   input  logic [mhtq_pkg::TMO_W-1:0]     req_timeout,
   input  logic [mhtq_pkg::TIME_BITS-1:0] req_now,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mhtq_pkg::ID_W-1:0]      rsp_event_id,
   output logic [1:0]                     rsp_cause,
   output logic                           rsp_last
);
   import mhtq_pkg::*;

   op_type     op;
   status_type st;

   mhtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .op        (op)
   );

   mhtq_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .op           (op),
      .st           (st),
      .req_kind     (req_kind),
      .req_timer_id (req_timer_id),
      .req_timeout  (req_timeout),
      .req_now      (req_now),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_event_id (rsp_event_id),
      .rsp_cause    (rsp_cause),
      .rsp_last     (rsp_last)
   );

endmodule
